// File: rtl/slcc_pkg.sv
// shared types and constants for the shell line completeness check
// byte codes, quote and status encodings, scanner state struct; no dependencies
package slcc_pkg;

  localparam int MaxNesting = 255;
  localparam int DepthW     = $clog2(MaxNesting + 1);

  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChLparen = 8'h28;
  localparam logic [7:0] ChRparen = 8'h29;
  localparam logic [7:0] ChBslash = 8'h5C;

  typedef enum logic [1:0] {
    QkNone   = 2'd0,
    QkDouble = 2'd1,
    QkSingle = 2'd2
  } quote_e;

  typedef enum logic [1:0] {
    StComplete   = 2'd0,
    StIncomplete = 2'd1,
    StStray      = 2'd2,
    StOverflow   = 2'd3
  } status_e;

  typedef struct packed {
    quote_e              quote_kind;
    logic                escape_pending;
    logic                in_nesting;
    logic                prev_was_backslash;
    logic [DepthW-1:0]   nest_depth;
    status_e             error_code;   // StComplete means nothing latched
  } scan_state_t;

  localparam scan_state_t StateReset = '{
    quote_kind:         QkNone,
    escape_pending:     1'b0,
    in_nesting:         1'b0,
    prev_was_backslash: 1'b0,
    nest_depth:         '0,
    error_code:         StComplete
  };

endpackage

// File: rtl/shell_line_completeness_check.sv
// top level of the shell line completeness check: input register, scanner state, result register
// depends on slcc_pkg and slcc_step
// Takes one line byte per word and reports one status word per zero-terminated
// line (0 complete, 1 incomplete, 2 stray close paren, 3 nesting overflow).
// A byte is held in the input register and then scanned by combinational logic
// against the scanner state register, so one byte per cycle is sustained while
// input is not stalled. A status passes through the input register and then
// the result register before it is offered. Input stalls only when a terminator
// is waiting and the status register still holds an untaken word.
module shell_line_completeness_check
  import slcc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] ch_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] status_o
);

  logic        in_valid_q;
  logic [7:0]  ch_q;
  scan_state_t state_q, state_d;
  status_e     status_d;
  status_e     status_q;
  logic        out_valid_q;
  logic        out_free;
  logic        is_term;
  logic        advance;

  assign out_free   = !out_valid_q || out_ready_i;
  assign is_term    = (ch_q == ChNul);
  assign advance    = in_valid_q && (!is_term || out_free);
  assign in_ready_o = !in_valid_q || advance;

  slcc_step u_step (
    .cur_i    (state_q),
    .ch_i     (ch_q),
    .nxt_o    (state_d),
    .status_o (status_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      ch_q <= ch_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && is_term) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && is_term) begin
      status_q <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;

endmodule

// File: rtl/slcc_step.sv
// next-state and status logic for one line byte
// depends on slcc_pkg
module slcc_step
  import slcc_pkg::*;
(
  input  scan_state_t cur_i,
  input  logic [7:0]  ch_i,
  output scan_state_t nxt_o,
  output status_e     status_o
);

  logic              is_lp, is_rp, is_bs, is_dq, is_sq;
  logic              esc;
  quote_e            q;
  logic [DepthW-1:0] dep_dec;

  assign is_lp = (ch_i == ChLparen);
  assign is_rp = (ch_i == ChRparen);
  assign is_bs = (ch_i == ChBslash);
  assign is_dq = (ch_i == ChDquote);
  assign is_sq = (ch_i == ChSquote);

  always_comb begin
    nxt_o    = cur_i;
    status_o = StComplete;
    esc      = 1'b0;
    q        = cur_i.quote_kind;
    dep_dec  = (cur_i.nest_depth != '0) ? cur_i.nest_depth - 1'b1 : cur_i.nest_depth;

    if (ch_i == ChNul) begin
      if (cur_i.error_code != StComplete) begin
        status_o = cur_i.error_code;
      end else if (cur_i.in_nesting || cur_i.escape_pending ||
                   cur_i.quote_kind != QkNone) begin
        status_o = StIncomplete;
      end
      nxt_o = StateReset;
    end else if (cur_i.error_code != StComplete) begin
      // latched error: rest of the line is ignored
      nxt_o = cur_i;
    end else if (cur_i.in_nesting) begin
      // nesting mode: escape is just the previous byte being a backslash
      esc = cur_i.prev_was_backslash;
      if (is_lp && !esc) begin
        if (cur_i.nest_depth >= DepthW'(MaxNesting)) begin
          nxt_o.error_code = StOverflow;
        end else begin
          nxt_o.nest_depth         = cur_i.nest_depth + 1'b1;
          nxt_o.prev_was_backslash = 1'b0;
        end
      end else if (is_rp && !esc) begin
        nxt_o.nest_depth = dep_dec;
        nxt_o.prev_was_backslash = 1'b0;
        if (dep_dec == '0) begin
          nxt_o.in_nesting = 1'b0;
        end
      end else begin
        nxt_o.prev_was_backslash = is_bs;
      end
    end else begin
      esc = cur_i.escape_pending;
      if (cur_i.quote_kind != QkSingle && is_bs && !esc) begin
        nxt_o.escape_pending = 1'b1;
      end else begin
        if (!esc) begin
          if (cur_i.quote_kind == QkNone) begin
            if (is_dq) begin
              q = QkDouble;
            end else if (is_sq) begin
              q = QkSingle;
            end
          end else if ((cur_i.quote_kind == QkDouble && is_dq) ||
                       (cur_i.quote_kind == QkSingle && is_sq)) begin
            q = QkNone;
          end
        end
        nxt_o.quote_kind = q;
        if (q == QkNone && !esc && is_lp) begin
          nxt_o.in_nesting         = 1'b1;
          nxt_o.nest_depth         = DepthW'(1);
          nxt_o.prev_was_backslash = 1'b0;
          nxt_o.escape_pending     = 1'b0;
        end else if (q == QkNone && !esc && is_rp) begin
          nxt_o.error_code = StStray;
        end else begin
          nxt_o.escape_pending = 1'b0;
        end
      end
    end
  end

endmodule

// File: rtl/slcc_checker.sv
// port-level checks for shell_line_completeness_check, bound to the top level
// depends on slcc_pkg
module slcc_checker
  import slcc_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] ch_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] status_o
);

  // a waiting status word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("status word changed or dropped while stalled");

  // input only stalls behind a blocked status word
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output back-pressure");

  // a fresh status word comes from a taken terminator
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && ch_i == ChNul, 2))
    else $error("status word without a terminator");

  // back-to-back terminators on an idle block: the second line is empty
  a_empty_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && ch_i == ChNul && !out_valid_o
    ##1 in_valid_i && in_ready_o && ch_i == ChNul && out_ready_i
    ##1 out_ready_i |=> out_valid_o && status_o == StComplete)
    else $error("empty line not reported complete");

endmodule

bind shell_line_completeness_check slcc_checker u_slcc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .ch_i        (ch_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o)
);
